// ===== rtl/scd_pkg.sv =====
package scd_pkg;

  // message mode codes
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_ENABLE  = 2'd1;
  localparam logic [1:0] MODE_DISABLE = 2'd2;
  localparam logic [1:0] MODE_DISPLAY = 2'd3;

  // reply sequence phase codes
  localparam logic [2:0] PHASE_IDLE   = 3'd0;
  localparam logic [2:0] PHASE_O_SENT = 3'd1;
  localparam logic [2:0] PHASE_K_SENT = 3'd2;
  localparam logic [2:0] PHASE_CR_SENT = 3'd3;
  localparam logic [2:0] PHASE_LF_SENT = 3'd4;

  // ascii codes
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_Q  = 8'h51;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;

  localparam logic [3:0] BLANK_DIGIT = 4'hA;

  // input item kinds carried on tuser
  localparam logic FUNC_RX_BYTE = 1'b0;
  localparam logic FUNC_TX_READY = 1'b1;

  localparam int unsigned OUT_BITS = 64;

  typedef struct packed {
    logic [7:0]  pending_replies;
    logic [7:0]  process_enables;
    logic [31:0] display_digits;
    logic        tx_active;
    logic [7:0]  tx_byte;
    logic        tx_valid;
  } result_t;

endpackage

// ===== rtl/serial_command_decoder_with_ack_top.sv =====
// serial command decoder with ok acknowledgement
//
// input channel (s_axis_*): one transfer per event. s_axis_tuser is the event
// kind: 0 = a received serial byte in s_axis_tdata, 1 = the transmitter can
// take its next byte (tdata is then ignored).
// output channel (m_axis_*): exactly one result transfer per input transfer,
// in order. it carries the reply byte to send (if any), the sender status,
// the packed display digits, the process enable bits and the count of ok
// replies still waiting to start.
// the result is registered and presented in the cycle after the input transfer.
// throughput: one item per cycle while the receiver takes each result; the
// whole decode and state update is one level of compare-and-select logic
// between the state registers and the result register.
// stall: s_axis_tready = !m_axis_tvalid || m_axis_tready, so a new item is
// taken in the same cycle the waiting result leaves; while the receiver holds
// off, the result register and all state hold.
// reset (rst, synchronous): digits blank, mode none, no replies pending,
// enables cleared, sender off, output channel empty.
module serial_command_decoder_with_ack_top #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] tx_active, [41:10] display_digits,
  // [49:42] process_enables, [57:50] pending_replies, [63:58] zero
  output logic [63:0] m_axis_tdata
);

  localparam int unsigned SHOWN = (DIGIT_COUNT < 8) ? DIGIT_COUNT : 8;

  // state
  logic [3:0] digits [DIGIT_COUNT];
  logic [3:0] digits_next [DIGIT_COUNT];
  logic [1:0] mode, mode_next;
  logic [2:0] phase, phase_next;
  logic [7:0] count, count_next;
  logic [7:0] enables, enables_next;
  logic       sender_on, sender_on_next;

  // result register
  scd_pkg::result_t result, result_next;
  logic             out_valid;

  logic       take;
  logic [7:0] rx;
  logic [3:0] n;
  logic [7:0] bit_mask;
  logic       sent;
  logic [7:0] sent_byte;

  assign take          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign rx            = s_axis_tdata;
  assign n             = rx[3:0];
  assign bit_mask      = 8'd1 << (n - 4'd1);

  // next state for one item
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digits_next[i] = digits[i];
    end
    mode_next      = mode;
    phase_next     = phase;
    count_next     = count;
    enables_next   = enables;
    sender_on_next = sender_on;
    sent           = 1'b0;
    sent_byte      = 8'd0;

    if (s_axis_tuser == scd_pkg::FUNC_RX_BYTE) begin
      unique case (rx)
        scd_pkg::CH_S: mode_next = scd_pkg::MODE_ENABLE;
        scd_pkg::CH_Q: mode_next = scd_pkg::MODE_DISABLE;
        scd_pkg::CH_C: begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            digits_next[i] = scd_pkg::BLANK_DIGIT;
          end
        end
        scd_pkg::CH_N: begin
          mode_next = scd_pkg::MODE_DISPLAY;
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            digits_next[i] = scd_pkg::BLANK_DIGIT;
          end
        end
        scd_pkg::CH_A, scd_pkg::CH_T, scd_pkg::CH_CR: begin
          // ignored
        end
        scd_pkg::CH_LF: begin
          // end of message: queue one reply, saturating
          mode_next = scd_pkg::MODE_NONE;
          if (count != 8'hFF) begin
            count_next = count + 8'd1;
          end
          sender_on_next = 1'b1;
        end
        default: begin
          if (mode == scd_pkg::MODE_DISPLAY) begin
            // shift digits up, new value enters at digit 0
            for (int i = 1; i < DIGIT_COUNT; i++) begin
              digits_next[i] = digits[i-1];
            end
            digits_next[0] = n;
          end else if (n >= 4'd1 && n <= 4'd8) begin
            if (mode == scd_pkg::MODE_ENABLE) begin
              enables_next = enables | bit_mask;
            end else if (mode == scd_pkg::MODE_DISABLE) begin
              enables_next = enables & ~bit_mask;
            end
          end
        end
      endcase
    end else if (sender_on) begin
      unique case (phase)
        scd_pkg::PHASE_IDLE: begin
          if (count != 8'd0) begin
            count_next = count - 8'd1;
          end
          phase_next = scd_pkg::PHASE_O_SENT;
          sent       = 1'b1;
          sent_byte  = scd_pkg::CH_O;
        end
        scd_pkg::PHASE_O_SENT: begin
          phase_next = scd_pkg::PHASE_K_SENT;
          sent       = 1'b1;
          sent_byte  = scd_pkg::CH_K;
        end
        scd_pkg::PHASE_K_SENT: begin
          phase_next = scd_pkg::PHASE_CR_SENT;
          sent       = 1'b1;
          sent_byte  = scd_pkg::CH_CR;
        end
        scd_pkg::PHASE_CR_SENT: begin
          phase_next = scd_pkg::PHASE_LF_SENT;
          sent       = 1'b1;
          sent_byte  = scd_pkg::CH_LF;
        end
        scd_pkg::PHASE_LF_SENT: begin
          // reply done; stay on if more are queued
          phase_next = scd_pkg::PHASE_IDLE;
          if (count == 8'd0) begin
            sender_on_next = 1'b0;
          end
        end
        default: phase_next = scd_pkg::PHASE_IDLE;
      endcase
    end
  end

  // pack the result from the state after this item
  always_comb begin
    result_next                 = '0;
    result_next.tx_valid        = sent;
    result_next.tx_byte         = sent_byte;
    result_next.tx_active       = sender_on_next;
    result_next.process_enables = enables_next;
    result_next.pending_replies = count_next;
    for (int i = 0; i < SHOWN; i++) begin
      result_next.display_digits[4*i +: 4] = digits_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits[i] <= scd_pkg::BLANK_DIGIT;
      end
      mode      <= scd_pkg::MODE_NONE;
      phase     <= scd_pkg::PHASE_IDLE;
      count     <= 8'd0;
      enables   <= 8'd0;
      sender_on <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digits[i] <= digits_next[i];
        end
        mode      <= mode_next;
        phase     <= phase_next;
        count     <= count_next;
        enables   <= enables_next;
        sender_on <= sender_on_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(scd_pkg::OUT_BITS - $bits(scd_pkg::result_t)){1'b0}}, result};

`ifndef SYNTHESIS
  // a reply in progress always has the sender switched on
  assert property (@(posedge clk) disable iff (rst)
    phase != scd_pkg::PHASE_IDLE |-> sender_on)
    else $error("reply phase active while sender off");

  // a sent reply byte leaves the sender on
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result.tx_valid |-> result.tx_active)
    else $error("reply byte sent with sender off");

  // reply byte field is zero when nothing is sent
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.tx_valid |-> result.tx_byte == 8'd0)
    else $error("stray reply byte");

  // pending count holds while no item is taken
  assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(count))
    else $error("pending count changed without a transfer");
`endif

endmodule

// ===== tb/scd_decoder_monitor.sv =====
module scd_decoder_monitor #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] tx_active, [41:10] display_digits,
  // [49:42] process_enables, [57:50] pending_replies, [63:58] zero
  input  logic [63:0] m_axis_tdata,
  output int          fail_count,
  output int          open_count
);

  // shadow state of the decoder
  logic [3:0] digit_q [DIGIT_COUNT];
  logic [1:0] mode_q;
  logic [2:0] phase_q;
  logic [7:0] pending_q;
  logic [7:0] enables_q;
  logic       sender_q;

  scd_pkg::result_t predicted_q [$];
  int               mismatch_total;

  task automatic blank_digits();
    for (int i = 0; i < DIGIT_COUNT; i++) digit_q[i] = scd_pkg::BLANK_DIGIT;
  endtask

  // advances the shadow state by one event and returns the status it yields
  task automatic decode_event(input logic func, input logic [7:0] rx,
                              output scd_pkg::result_t r);
    logic [3:0] n;
    r = '0;
    if (func == scd_pkg::FUNC_RX_BYTE) begin
      case (rx)
        scd_pkg::CH_S: mode_q = scd_pkg::MODE_ENABLE;
        scd_pkg::CH_Q: mode_q = scd_pkg::MODE_DISABLE;
        scd_pkg::CH_C: blank_digits();
        scd_pkg::CH_N: begin
          mode_q = scd_pkg::MODE_DISPLAY;
          blank_digits();
        end
        scd_pkg::CH_A, scd_pkg::CH_T, scd_pkg::CH_CR: ;
        scd_pkg::CH_LF: begin
          mode_q = scd_pkg::MODE_NONE;
          if (pending_q != 8'hFF) pending_q = pending_q + 8'd1;
          sender_q = 1'b1;
        end
        default: begin
          n = rx[3:0];
          if (mode_q == scd_pkg::MODE_DISPLAY) begin
            for (int i = DIGIT_COUNT - 1; i > 0; i--) digit_q[i] = digit_q[i-1];
            digit_q[0] = n;
          end else if (n >= 4'd1 && n <= 4'd8) begin
            if (mode_q == scd_pkg::MODE_ENABLE) enables_q[n-1] = 1'b1;
            else if (mode_q == scd_pkg::MODE_DISABLE) enables_q[n-1] = 1'b0;
          end
        end
      endcase
    end else if (sender_q) begin
      case (phase_q)
        scd_pkg::PHASE_IDLE: begin
          if (pending_q != 8'd0) pending_q = pending_q - 8'd1;
          phase_q = scd_pkg::PHASE_O_SENT;
          r.tx_valid = 1'b1;
          r.tx_byte = scd_pkg::CH_O;
        end
        scd_pkg::PHASE_O_SENT: begin
          phase_q = scd_pkg::PHASE_K_SENT;
          r.tx_valid = 1'b1;
          r.tx_byte = scd_pkg::CH_K;
        end
        scd_pkg::PHASE_K_SENT: begin
          phase_q = scd_pkg::PHASE_CR_SENT;
          r.tx_valid = 1'b1;
          r.tx_byte = scd_pkg::CH_CR;
        end
        scd_pkg::PHASE_CR_SENT: begin
          phase_q = scd_pkg::PHASE_LF_SENT;
          r.tx_valid = 1'b1;
          r.tx_byte = scd_pkg::CH_LF;
        end
        scd_pkg::PHASE_LF_SENT: begin
          phase_q = scd_pkg::PHASE_IDLE;
          if (pending_q == 8'd0) sender_q = 1'b0;
        end
        default: phase_q = scd_pkg::PHASE_IDLE;
      endcase
    end
    r.tx_active = sender_q;
    for (int i = 0; i < 8; i++)
      if (i < DIGIT_COUNT) r.display_digits[4*i +: 4] = digit_q[i];
    r.process_enables = enables_q;
    r.pending_replies = pending_q;
  endtask

  always @(posedge clk) begin
    scd_pkg::result_t got;
    scd_pkg::result_t want;
    if (rst) begin
      blank_digits();
      mode_q = scd_pkg::MODE_NONE;
      phase_q = scd_pkg::PHASE_IDLE;
      pending_q = '0;
      enables_q = '0;
      sender_q = 1'b0;
      predicted_q.delete();
      mismatch_total = 0;
      fail_count <= 0;
      open_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = scd_pkg::result_t'(m_axis_tdata[$bits(scd_pkg::result_t)-1:0]);
        if (predicted_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: result transfer with nothing expected: %h", $time, m_axis_tdata);
        end else begin
          want = predicted_q.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.tx_active !== want.tx_active ||
              got.display_digits !== want.display_digits ||
              got.process_enables !== want.process_enables ||
              got.pending_replies !== want.pending_replies) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: exp valid=%0d byte=%h active=%0d digits=%h en=%h pend=%0d",
                       $time, want.tx_valid, want.tx_byte, want.tx_active,
                       want.display_digits, want.process_enables, want.pending_replies);
              $display("%0t: got valid=%0d byte=%h active=%0d digits=%h en=%h pend=%0d",
                       $time, got.tx_valid, got.tx_byte, got.tx_active,
                       got.display_digits, got.process_enables, got.pending_replies);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_event(s_axis_tuser, s_axis_tdata, want);
        predicted_q.push_back(want);
      end
      fail_count <= mismatch_total;
      open_count <= predicted_q.size();
    end
  end

endmodule

// ===== tb/serial_command_decoder_with_ack_top_tb.sv =====
module serial_command_decoder_with_ack_top_tb;

  localparam int unsigned DIGITS = 8;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] tx_valid, [8:1] tx_byte, [9] tx_active, [41:10] display_digits,
  // [49:42] process_enables, [57:50] pending_replies, [63:58] zero
  logic [63:0] m_axis_tdata;

  int          fail_count;
  int          open_count;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned item_count = 0;
  logic        calm = 1'b0;   // while set, no new idle gaps or stalls begin
  logic        flooded = 1'b0;

  serial_command_decoder_with_ack_top #(.DIGIT_COUNT(DIGITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  scd_decoder_monitor #(.DIGIT_COUNT(DIGITS)) monitor (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .open_count   (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // calm stretches come and go so back-to-back transfers also occur
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm <= !calm;
  end

  // hard limit on run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("serial_command_decoder_with_ack_top test failed");
      $finish;
    end
  end

  // result side: random backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one input transfer, preceded by a random gap; valid stays high across
  // back-to-back items
  task automatic send_event(input logic func, input logic [7:0] rx);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= rx;
    do @(posedge clk); while (!s_axis_tready);
    item_count++;
  endtask

  // transmitter-ready event; tdata carries random junk that must be ignored
  task automatic tx_ready();
    send_event(scd_pkg::FUNC_TX_READY, 8'($urandom_range(0, 255)));
  endtask

  task automatic tx_ready_burst(input int unsigned count);
    repeat (count) tx_ready();
  endtask

  // a message body byte: mostly ascii digits, sometimes any byte, an ignored letter, a clear or a ready event
  task automatic send_payload();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4, 5: send_event(scd_pkg::FUNC_RX_BYTE, 8'h30 + 8'($urandom_range(0, 9)));
      6: send_event(scd_pkg::FUNC_RX_BYTE, 8'($urandom_range(0, 255)));
      7: begin
        case ($urandom_range(0, 2))
          0: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_A);
          1: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_T);
          default: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_CR);
        endcase
      end
      8: tx_ready();
      default: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_C);
    endcase
  endtask

  // command letter, a few body bytes, usually a cr lf ending
  task automatic send_message();
    int unsigned body_len;
    int unsigned ending;
    case ($urandom_range(0, 3))
      0: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_S);
      1: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_Q);
      2: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_N);
      default: send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_C);
    endcase
    body_len = $urandom_range(1, 9);
    repeat (body_len) send_payload();
    ending = $urandom_range(0, 19);
    if (ending < 16) begin
      send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_CR);
      send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_LF);
    end else if (ending < 18) begin
      send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_LF);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: display mode with digit extremes and out-of-range nibbles
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_N);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h30);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h39);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'hFF);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h00);
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_C);
    // enable mode: ends of the process range, then values out of range
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_S);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h31);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h38);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h30);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h39);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h3F);
    // disable mode and the ignored letters
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_Q);
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h31);
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_A);
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_T);
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_CR);
    send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_LF);
    // full ok cr lf reply, then the closing event that turns the sender off
    tx_ready_burst(5);
    // byte in no mode, and a ready event while the sender is off
    send_event(scd_pkg::FUNC_RX_BYTE, 8'h5A);
    tx_ready();

    // random traffic: mostly well-formed messages with interleaved replies
    while (item_count < ITEM_TARGET) begin
      if (!flooded && item_count > ITEM_TARGET / 2) begin
        // pile up more line feeds than the reply counter can hold
        flooded = 1'b1;
        repeat (260) send_event(scd_pkg::FUNC_RX_BYTE, scd_pkg::CH_LF);
        tx_ready_burst(12);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_message();
        6, 7: tx_ready_burst($urandom_range(1, 12));
        8: send_event(scd_pkg::FUNC_RX_BYTE, 8'($urandom_range(0, 255)));
        default: send_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    // drain: every expected result must come back
    while (open_count != 0 || m_axis_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("serial_command_decoder_with_ack_top test passed");
    end else begin
      $display("serial_command_decoder_with_ack_top test failed");
    end
    $finish;
  end

endmodule
